>>> src/aging_page_replacement_core_assert.svh
// Assertion macros shared by the aging page replacement core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef AGING_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define AGING_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define APR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define APR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/apr_pkg.sv
// Package for the aging page replacement core: widths, reset values,
// controller states and the command and status structs.
// No dependencies.
package apr_pkg;

  localparam int PAGE_W         = 8;
  localparam int CFG_W          = 4;
  localparam int TOTAL_W        = 16;
  localparam int MAX_FRAMES_DEF = 8;
  localparam int AGE_BITS_DEF   = 8;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_DECIDE,
    S_AGE,
    S_AGE_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic sweep;
    logic decide;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_rd;
  } dp_stat_t;

endpackage

>>> src/apr_datapath.sv
// Datapath of the aging page replacement core: frame memory, match and
// minimum-age scan, replacement decision, aging sweep and result register.
// Depends on apr_pkg.
module apr_datapath #(
  parameter int MAX_FRAMES = apr_pkg::MAX_FRAMES_DEF,
  parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  apr_pkg::dp_cmd_t            cmd,
  output apr_pkg::dp_stat_t           stat,
  input  logic                        cfg_we,
  input  logic [apr_pkg::CFG_W-1:0]   cfg_data,
  input  logic [apr_pkg::PAGE_W-1:0]  page_in,
  output logic                        hit,
  output logic                        replaced,
  output logic [apr_pkg::PAGE_W-1:0]  victim_page,
  output logic [apr_pkg::TOTAL_W-1:0] replacement_total
);
  import apr_pkg::*;

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam int EW = PAGE_W + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

  logic [EW-1:0]       mem [MAX_FRAMES];
  logic [EW-1:0]       rd_data;
  logic [CW-1:0]       cnt;
  logic [FW-1:0]       tag;
  logic                pend;
  logic [PAGE_W-1:0]   page_q;
  logic                hit_q;
  logic [FW-1:0]       hit_slot;
  logic                min_found;
  logic [AGE_BITS-1:0] min_age;
  logic [FW-1:0]       min_slot;
  logic [PAGE_W-1:0]   min_page;
  logic [FW-1:0]       slot;
  logic                repl_q;
  logic [PAGE_W-1:0]   victim_q;
  logic [CW-1:0]       occ;
  logic [TOTAL_W-1:0]  rtotal;
  logic [CFG_W-1:0]    fiu;

  logic [PAGE_W-1:0]   rd_page;
  logic [AGE_BITS-1:0] rd_age;
  logic [AGE_BITS-1:0] age_shift;
  logic                tag_valid;
  logic                scan_eval;
  logic [LW-1:0]       lim;
  logic                fill_ok;
  logic                wr_en;
  logic [EW-1:0]       wr_data;

  assign rd_page   = rd_data[EW-1:AGE_BITS];
  assign rd_age    = rd_data[AGE_BITS-1:0];
  assign age_shift = rd_age >> 1;
  assign tag_valid = CW'(tag) < occ;
  assign scan_eval = pend && !cmd.sweep;
  assign fill_ok   = LW'(occ) < lim;
  assign stat.last_rd = (cnt == CW'(MAX_FRAMES - 1));

  always_comb begin
    priority if (fiu == '0) begin
      lim = LW'(1);
    end else if (LW'(fiu) > LW'(MAX_FRAMES)) begin
      lim = LW'(MAX_FRAMES);
    end else begin
      lim = LW'(fiu);
    end
  end

  always_comb begin
    wr_en = pend && cmd.sweep && ((tag == slot) || tag_valid);
    if (tag == slot) begin
      wr_data = {page_q, AGE_TOP | (hit_q ? age_shift : '0)};
    end else begin
      wr_data = {rd_page, age_shift};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tag] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[cnt[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      occ    <= '0;
      rtotal <= '0;
      fiu    <= FRAMES_RESET;
    end else begin
      pend <= cmd.rd;
      if (cfg_we) begin
        fiu <= cfg_data;
      end
      if (cmd.decide && !hit_q) begin
        if (fill_ok) begin
          occ <= occ + 1'b1;
        end else if (rtotal != '1) begin
          rtotal <= rtotal + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      page_q    <= page_in;
      hit_q     <= 1'b0;
      min_found <= 1'b0;
      cnt       <= '0;
    end
    if (cmd.rd) begin
      cnt <= cnt + 1'b1;
      tag <= cnt[FW-1:0];
    end
    if (scan_eval && tag_valid) begin
      if (rd_page == page_q) begin
        hit_q    <= 1'b1;
        hit_slot <= tag;
      end
      if (!min_found || (rd_age < min_age)) begin
        min_found <= 1'b1;
        min_age   <= rd_age;
        min_slot  <= tag;
        min_page  <= rd_page;
      end
    end
    if (cmd.decide) begin
      cnt <= '0;
      priority if (hit_q) begin
        slot     <= hit_slot;
        repl_q   <= 1'b0;
        victim_q <= '0;
      end else if (fill_ok) begin
        slot     <= occ[FW-1:0];
        repl_q   <= 1'b0;
        victim_q <= '0;
      end else begin
        slot     <= min_slot;
        repl_q   <= 1'b1;
        victim_q <= min_page;
      end
    end
    if (cmd.load_out) begin
      hit               <= hit_q;
      replaced          <= repl_q;
      victim_page       <= victim_q;
      replacement_total <= rtotal;
    end
  end

endmodule

>>> src/apr_ctrl.sv
// Controller of the aging page replacement core: sequences the scan, the
// decision, the aging sweep and the result handoff. Depends on apr_pkg.
`include "aging_page_replacement_core_assert.svh"
module apr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  apr_pkg::dp_stat_t stat,
  output apr_pkg::dp_cmd_t  cmd
);
  import apr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr    = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (stat.last_rd) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_AGE;
      end
      S_AGE: begin
        cmd.rd    = 1'b1;
        cmd.sweep = 1'b1;
        if (stat.last_rd) begin
          state_next = S_AGE_LAST;
        end
      end
      S_AGE_LAST: begin
        cmd.sweep  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `APR_ASSERT_NXT(a_accept_starts_scan, in_valid && in_ready, state == S_SCAN, "accepted transaction did not start the scan")
  `APR_ASSERT_NXT(a_decide_then_age, state == S_DECIDE, state == S_AGE, "decision not followed by the aging sweep")
  `APR_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid || out_ready, "result register overwritten before transfer")
  `APR_ASSERT_IMP(a_result_from_done, $rose(out_valid), $past(state) == S_DONE, "result raised outside the handoff state")

endmodule

>>> src/aging_page_replacement_core.sv
// Top level of the aging page replacement core: controller plus datapath.
// Depends on apr_pkg, apr_ctrl and apr_datapath.
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    page_number
//   out       out_valid / out_ready  hit, replaced, victim_page, replacement_total
//   cfg       cfg_valid / cfg_ready  cfg_data (frames_in_use)
//
// A reference makes two passes over the frame memory's single read port, one to search
// and one to age every occupied frame.
// Reset is synchronous and needs no clearing pass; the frame memory is not cleared.
// The result register lets the next reference be accepted while a result waits.
// A stalled output holds the finished reference in its handoff state.
module aging_page_replacement_core #(
  parameter int MAX_FRAMES = apr_pkg::MAX_FRAMES_DEF,
  parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [apr_pkg::PAGE_W-1:0]  page_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic                        replaced,
  output logic [apr_pkg::PAGE_W-1:0]  victim_page,
  output logic [apr_pkg::TOTAL_W-1:0] replacement_total,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [apr_pkg::CFG_W-1:0]   cfg_data
);
  import apr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  apr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  apr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .AGE_BITS   (AGE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_valid),
    .cfg_data          (cfg_data),
    .page_in           (page_number),
    .hit               (hit),
    .replaced          (replaced),
    .victim_page       (victim_page),
    .replacement_total (replacement_total)
  );

endmodule
